@@ design/mqsr_pkg.sv @@
// Shared types and codes for the mailbox queue with selective receive.
// Used by the controller, the output stage, the top level and the checker.
`default_nettype none

package mqsr_pkg;

	localparam int ID_W  = 32;
	localparam int LEN_W = 6;
	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		OP_SEND_START = 2'd0,
		OP_SEND_BYTE  = 2'd1,
		OP_RECEIVE    = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_ACCEPT = 3'd0,
		STS_REJECT = 3'd1,
		STS_HEADER = 3'd2,
		STS_BYTE   = 3'd3,
		STS_NO_MSG = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TAIL_SEEK,
		ST_RESP,
		ST_SCAN,
		ST_CHECK,
		ST_HDR,
		ST_BYTE_RD,
		ST_BYTE_OUT,
		ST_RELEASE,
		ST_HEAD_SEEK
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [ID_W-1:0]  receiver;
		logic [ID_W-1:0]  sender;
	} hdr_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   sender;
		logic [ID_W-1:0]   receiver;
		logic [LEN_W-1:0]  length;
		logic [BYTE_W-1:0] data;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

@@ design/mqsr_ctrl.sv @@
// Mailbox sequencer: used map, head and tail pointers, header and payload memories.
// Depends on mqsr_pkg; emits one result beat at a time to the output stage.
`default_nettype none

module mqsr_ctrl
	import mqsr_pkg::*;
#(
	parameter int QUEUE_SLOTS   = 32,
	parameter int MESSAGE_BYTES = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        in_op,
	input  wire logic [ID_W-1:0]   in_sender,
	input  wire logic [ID_W-1:0]   in_receiver,
	input  wire logic [31:0]       in_length,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              out_free,
	output logic                   res_valid,
	output result_t                res
);

	localparam int SW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int CW = $clog2(QUEUE_SLOTS + 1);
	localparam int PD = QUEUE_SLOTS * MESSAGE_BYTES;
	localparam int AW = (PD > 1) ? $clog2(PD) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_SLOTS - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_SLOTS);
	localparam logic [AW-1:0] MB_A      = AW'(MESSAGE_BYTES);
	localparam logic [31:0]   MB_LEN    = 32'(MESSAGE_BYTES);

	state_t state_q, state_d;
	op_t op;

	logic [QUEUE_SLOTS-1:0] used_q;
	logic [SW-1:0] head_q, tail_q, cur_q, fill_slot_q;
	logic [CW-1:0] count_q, scan_n_q;
	logic [LEN_W-1:0] fill_rem_q, fill_pos_q, req_len_q, msg_len_q, byte_pos_q;
	logic [ID_W-1:0] req_sender_q, req_receiver_q, msg_sender_q;
	status_t resp_status_q;

	hdr_t hdr_mem [QUEUE_SLOTS];
	hdr_t hdr_rd_q;
	logic [BYTE_W-1:0] pay_mem [PD];
	logic [BYTE_W-1:0] pay_rd_q;

	logic acc, reject, hdr_we, hdr_re, pay_we, pay_re, byte_last, found;
	logic [AW-1:0] pay_wr_addr, pay_rd_addr;
	logic [SW-1:0] tail_next, cur_next, head_next;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] i);
		return (i == LAST_SLOT) ? '0 : i + 1'b1;
	endfunction

	assign op        = op_t'(in_op);
	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign reject    = (in_length > MB_LEN) || (count_q == FULL_CNT);
	assign tail_next = next_slot(tail_q);
	assign cur_next  = next_slot(cur_q);
	assign head_next = next_slot(head_q);
	assign byte_last = ((byte_pos_q + 1'b1) == msg_len_q);
	assign found     = (hdr_rd_q.receiver == req_receiver_q);

	assign pay_wr_addr = AW'(fill_slot_q) * MB_A + AW'(fill_pos_q);
	assign pay_rd_addr = AW'(cur_q) * MB_A + AW'(byte_pos_q);

	// Payload writes happen only on an accepted beat in idle, reads only while a
	// receive runs, so the two never touch the same entry in overlapping cycles.
	assign pay_we = acc && (op == OP_SEND_BYTE) && (fill_rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		res_valid = 1'b0;
		res       = '{status: STS_ACCEPT, sender: '0, receiver: '0, length: '0,
			data: '0, last: 1'b1};
		hdr_we    = 1'b0;
		hdr_re    = 1'b0;
		pay_re    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (op)
						OP_SEND_START: state_d = reject ? ST_RESP : ST_TAIL_SEEK;
						OP_RECEIVE:    state_d = ST_SCAN;
						default:       state_d = ST_IDLE;
					endcase
				end
			end
			ST_TAIL_SEEK: begin
				if (!used_q[tail_q]) begin
					hdr_we  = 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					res_valid  = 1'b1;
					res.status = resp_status_q;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_n_q == FULL_CNT) begin
					state_d = ST_RESP;
				end else if (used_q[cur_q]) begin
					hdr_re  = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = found ? ST_HDR : ST_SCAN;
			end
			ST_HDR: begin
				if (out_free) begin
					res_valid    = 1'b1;
					res.status   = STS_HEADER;
					res.sender   = msg_sender_q;
					res.receiver = req_receiver_q;
					res.length   = msg_len_q;
					res.last     = (msg_len_q == '0);
					state_d      = (msg_len_q == '0) ? ST_RELEASE : ST_BYTE_RD;
				end
			end
			ST_BYTE_RD: begin
				pay_re  = 1'b1;
				state_d = ST_BYTE_OUT;
			end
			ST_BYTE_OUT: begin
				if (out_free) begin
					res_valid  = 1'b1;
					res.status = STS_BYTE;
					res.data   = pay_rd_q;
					res.last   = byte_last;
					state_d    = byte_last ? ST_RELEASE : ST_BYTE_RD;
				end
			end
			ST_RELEASE: begin
				state_d = (count_q == CW'(1)) ? ST_IDLE : ST_HEAD_SEEK;
			end
			ST_HEAD_SEEK: begin
				if (used_q[head_q]) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
			fill_slot_q   <= '0;
			fill_rem_q    <= '0;
			fill_pos_q    <= '0;
			cur_q         <= '0;
			scan_n_q      <= '0;
			byte_pos_q    <= '0;
			resp_status_q <= STS_ACCEPT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (op)
							OP_SEND_START: begin
								fill_rem_q    <= '0;
								resp_status_q <= STS_REJECT;
							end
							OP_SEND_BYTE: begin
								if (fill_rem_q != '0) begin
									fill_rem_q <= fill_rem_q - 1'b1;
									fill_pos_q <= fill_pos_q + 1'b1;
								end
							end
							OP_RECEIVE: begin
								cur_q    <= head_q;
								scan_n_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_TAIL_SEEK: begin
					tail_q <= tail_next;
					if (!used_q[tail_q]) begin
						used_q[tail_q] <= 1'b1;
						fill_slot_q    <= tail_q;
						count_q        <= count_q + 1'b1;
						fill_rem_q     <= req_len_q;
						fill_pos_q     <= '0;
						resp_status_q  <= STS_ACCEPT;
					end
				end
				ST_SCAN: begin
					if (scan_n_q == FULL_CNT) begin
						resp_status_q <= STS_NO_MSG;
					end else if (!used_q[cur_q]) begin
						cur_q    <= cur_next;
						scan_n_q <= scan_n_q + 1'b1;
					end
				end
				ST_CHECK: begin
					if (found) begin
						byte_pos_q <= '0;
					end else begin
						cur_q    <= cur_next;
						scan_n_q <= scan_n_q + 1'b1;
					end
				end
				ST_BYTE_OUT: begin
					if (out_free) begin
						byte_pos_q <= byte_pos_q + 1'b1;
					end
				end
				ST_RELEASE: begin
					used_q[cur_q] <= 1'b0;
					count_q       <= count_q - 1'b1;
					if ((fill_rem_q != '0) && (fill_slot_q == cur_q)) begin
						fill_rem_q <= '0;
					end
					if (count_q == CW'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end
				end
				ST_HEAD_SEEK: begin
					if (!used_q[head_q]) begin
						head_q <= head_next;
					end
				end
				default: ;
			endcase
		end
	end

	// Request and message header registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			req_sender_q   <= in_sender;
			req_receiver_q <= in_receiver;
			req_len_q      <= in_length[LEN_W-1:0];
		end
		if (state_q == ST_CHECK) begin
			msg_sender_q <= hdr_rd_q.sender;
			msg_len_q    <= hdr_rd_q.length;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[tail_q] <= '{length: req_len_q, receiver: req_receiver_q,
				sender: req_sender_q};
		end
		if (hdr_re) begin
			hdr_rd_q <= hdr_mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[pay_wr_addr] <= in_byte;
		end
		if (pay_re) begin
			pay_rd_q <= pay_mem[pay_rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ design/mqsr_out_stage.sv @@
// Output register of the mailbox: holds one result beat until the sink takes it.
// Depends on mqsr_pkg for the result type.
`default_nettype none

module mqsr_out_stage
	import mqsr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output logic         free,
	output logic         valid,
	input  wire logic    ready,
	output result_t      res_q
);

	logic valid_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ design/mailbox_queue_selective_receive.sv @@
// A send byte or unused op completes in idle; a rejected send start goes to its response,
// an accepted one first steps the tail past used slots. A receive scans from the head,
// reading used slots' headers; a match sends the header beat, reads and sends each payload
// byte, frees the slot and steps the head to the next used slot unless the store empties;
// no match answers no-message. One item is in work at a time; output stalls hold it. Reset
// clears the used map, pointers, count and fill state; the header and payload memories keep
// no reset value. Top level; depends on mqsr_pkg, mqsr_ctrl and mqsr_out_stage.
`default_nettype none

module mailbox_queue_selective_receive
	import mqsr_pkg::*;
#(
	parameter int QUEUE_SLOTS   = 32,
	parameter int MESSAGE_BYTES = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// sender_id[31:0], receiver_id[63:32], message_length[95:64], payload_byte[103:96]
	input  wire logic [103:0] s_axis_tdata,
	// op[1:0]
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// out_sender[31:0], out_receiver[63:32], out_length[69:64], out_byte[77:70], zero
	output logic [79:0]       m_axis_tdata,
	// status[2:0]
	output logic [2:0]        m_axis_tuser,
	output logic              m_axis_tlast
);

	logic    res_valid, out_free;
	result_t res, res_q;

	mqsr_ctrl #(
		.QUEUE_SLOTS   (QUEUE_SLOTS),
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_op       (s_axis_tuser),
		.in_sender   (s_axis_tdata[31:0]),
		.in_receiver (s_axis_tdata[63:32]),
		.in_length   (s_axis_tdata[95:64]),
		.in_byte     (s_axis_tdata[103:96]),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res         (res)
	);

	mqsr_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res    (res),
		.free   (out_free),
		.valid  (m_axis_tvalid),
		.ready  (m_axis_tready),
		.res_q  (res_q)
	);

	assign m_axis_tdata = {2'b00, res_q.data, res_q.length, res_q.receiver, res_q.sender};
	assign m_axis_tuser = res_q.status;
	assign m_axis_tlast = res_q.last;

endmodule

`default_nettype wire

@@ design/mqsr_checker.sv @@
// Port-level checks for the mailbox, attached to the top level by bind.
// Depends on mqsr_pkg for the status and op codes.
`default_nettype none

module mqsr_checker
	import mqsr_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [1:0]   s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [79:0]  m_axis_tdata,
	input wire logic [2:0]   m_axis_tuser,
	input wire logic         m_axis_tlast
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// Single-beat answers always close their item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STS_ACCEPT || m_axis_tuser == STS_REJECT
			|| m_axis_tuser == STS_NO_MSG) |-> m_axis_tlast)
		else $error("single-beat result without tlast");

	// A header closes the item exactly when the message is empty.
	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STS_HEADER)
			|-> m_axis_tlast == (m_axis_tdata[69:64] == 6'd0))
		else $error("header tlast does not match length");

	// Only header beats carry ids.
	a_ids_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STS_HEADER) |-> (m_axis_tdata[69:0] == '0))
		else $error("id or length field set outside a header");

	// Send starts and receives occupy the block for at least the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SEND_START
			|| s_axis_tuser == OP_RECEIVE) |=> !s_axis_tready)
		else $error("input taken while a request is in work");

endmodule

bind mailbox_queue_selective_receive mqsr_checker u_mqsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
